// ----- design/msr_pkg.sv -----
package msr_pkg;

	localparam int unsigned SLOTS = 4;
	localparam int unsigned MSG_BYTES = 256;
	localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned ADDR_W = $clog2(MSG_BYTES);
	localparam int unsigned MEM_AW = SLOT_W + ADDR_W;
	localparam int unsigned MEM_DEPTH = 2 ** MEM_AW;
	localparam int unsigned EMIT_MAX = (MSG_BYTES < 256) ? MSG_BYTES : 256;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	localparam logic [2:0] KIND_PAYLOAD = 3'd0;
	localparam logic [2:0] KIND_CSUM_FAIL = 3'd1;
	localparam logic [2:0] KIND_TOO_MANY = 3'd2;
	localparam logic [2:0] KIND_NO_SLOT = 3'd3;
	localparam logic [2:0] KIND_TIMEOUT = 3'd4;

	typedef struct packed {
		logic        cmd;
		logic [47:0] sender_id;
		logic [7:0]  total_chunks;
		logic [7:0]  chunk_offset;
		logic [7:0]  byte_pos;
		logic [7:0]  data_byte;
		logic        last_of_chunk;
		logic [7:0]  checksum_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [47:0] sender_of_result;
		logic [63:0] payload_word;
		logic [3:0]  bytes_valid;
		logic        last_word;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DATA,
		ST_TICK,
		ST_EMIT,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the accepted input
		logic do_data;    // apply a data byte to its slot
		logic tick_step;  // age the slot under the scan pointer
		logic emit_start; // begin reading the payload of the done slot
		logic emit_step;  // step the payload reads and word assembly
		logic out_take;   // output register was taken
	} ctrl_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic is_tick;
		logic out_full;   // a result waits in the output register
		logic emit_go;    // the data byte finished a good message
		logic tick_last;  // scan pointer on the final slot
		logic emit_busy;  // word assembly still running
	} stat_t;

endpackage

// ----- design/msr_ram.sv -----
module msr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/msr_ctrl.sv -----
module msr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           out_ready,
	input  msr_pkg::stat_t stat,
	output msr_pkg::ctrl_t ctrl
);

	msr_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			msr_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = msr_pkg::ST_DATA;
				end
			end
			msr_pkg::ST_DATA: begin
				if (stat.is_tick) begin
					state_d = msr_pkg::ST_TICK;
				end else if (!stat.out_full || out_ready) begin
					state_d = stat.emit_go ? msr_pkg::ST_EMIT : msr_pkg::ST_IDLE;
				end
			end
			msr_pkg::ST_TICK: begin
				if ((!stat.out_full || out_ready) && stat.tick_last) begin
					state_d = msr_pkg::ST_IDLE;
				end
			end
			msr_pkg::ST_EMIT: begin
				state_d = msr_pkg::ST_OUT;
			end
			msr_pkg::ST_OUT: begin
				if (!stat.emit_busy && (!stat.out_full || out_ready)) begin
					state_d = msr_pkg::ST_IDLE;
				end
			end
			default: state_d = msr_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		ctrl = '0;
		in_ready = 1'b0;
		ctrl.out_take = out_ready & stat.out_full;
		case (state_q)
			msr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				ctrl.load = in_valid;
			end
			msr_pkg::ST_DATA: begin
				ctrl.do_data = !stat.is_tick && (!stat.out_full || out_ready);
			end
			msr_pkg::ST_TICK: begin
				ctrl.tick_step = !stat.out_full || out_ready;
			end
			msr_pkg::ST_EMIT: begin
				ctrl.emit_start = 1'b1;
			end
			msr_pkg::ST_OUT: begin
				ctrl.emit_step = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ----- design/msr_dp.sv -----
module msr_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  msr_pkg::in_item_t  in_item,
	input  msr_pkg::ctrl_t     ctrl,
	input  logic               out_ready,
	output msr_pkg::stat_t     stat,
	output logic               out_valid,
	output msr_pkg::out_item_t out_item
);

	localparam int unsigned S = msr_pkg::SLOTS;
	localparam int unsigned SW = msr_pkg::SLOT_W;

	logic [15:0]       timeout_q;
	msr_pkg::in_item_t item_q;
	logic [47:0]       sender_q [S];
	logic [7:0]        chunks_q [S];
	logic [8:0]        bytes_q  [S];
	logic [7:0]        xor_q    [S];
	logic [15:0]       age_q    [S];
	logic [SW-1:0]     scan_q;
	logic              out_full_q;
	msr_pkg::out_item_t out_q;

	// Emission state.
	logic [SW-1:0]     eslot_q;
	logic [47:0]       esender_q;
	logic [8:0]        elen_q;
	logic [8:0]        rd_ptr_q;
	logic              rd_pend_q;
	logic [3:0]        wbyte_q;
	logic [8:0]        wcount_q;
	logic [63:0]       word_q;
	logic              emit_busy_q;

	// Slot lookup.
	logic          hit, free_any;
	logic [SW-1:0] hit_idx, free_idx, slot;
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = S - 1; i >= 0; i--) begin
			if (sender_q[i] == item_q.sender_id) begin
				hit = 1'b1;
				hit_idx = SW'(i);
			end
			if (sender_q[i] == 48'd0) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
		end
		slot = hit ? hit_idx : free_idx;
	end

	// Per-byte update values.
	logic [7:0] cur_chunks, new_chunks, new_xor;
	logic [8:0] cur_bytes, new_bytes;
	logic [8:0] addr_sum;
	logic       too_many, done, good, store_ok;
	always_comb begin
		cur_chunks = hit ? chunks_q[slot] : 8'd0;
		cur_bytes  = hit ? bytes_q[slot] : 9'd0;
		new_xor    = (hit ? xor_q[slot] : 8'd0) ^ item_q.data_byte;
		new_bytes  = (cur_bytes == 9'd511) ? cur_bytes : cur_bytes + 9'd1;
		new_chunks = (item_q.last_of_chunk && cur_chunks != 8'd255) ?
			cur_chunks + 8'd1 : cur_chunks;
		too_many   = cur_chunks > item_q.total_chunks;
		done       = item_q.last_of_chunk && new_chunks == item_q.total_chunks;
		good       = (new_xor ^ item_q.checksum_byte) == 8'd0;
		addr_sum   = {1'b0, item_q.chunk_offset} + {1'b0, item_q.byte_pos};
		store_ok   = {1'b0, addr_sum} < 10'(msr_pkg::MSG_BYTES);
	end

	logic data_ok;
	assign data_ok = item_q.sender_id != 48'd0 && (hit || free_any);

	// Tick aging for the slot under the scan pointer.
	logic [15:0] aged;
	logic        scan_busy, timed_out;
	assign scan_busy = sender_q[scan_q] != 48'd0;
	assign aged = (age_q[scan_q] == 16'hFFFF) ? age_q[scan_q] : age_q[scan_q] + 16'd1;
	assign timed_out = scan_busy && aged >= timeout_q;

	// Payload memory.
	logic                       mem_we;
	logic [msr_pkg::MEM_AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]                 mem_rdata;
	assign mem_we = ctrl.do_data && data_ok && !too_many && store_ok;
	assign mem_waddr = {slot, addr_sum[msr_pkg::ADDR_W-1:0]};
	assign mem_raddr = {eslot_q, rd_ptr_q[msr_pkg::ADDR_W-1:0]};

	msr_ram #(
		.WIDTH(8),
		.DEPTH(msr_pkg::MEM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(item_q.data_byte),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Payload length of the completing slot.
	logic [8:0] emit_len;
	always_comb begin
		emit_len = new_bytes;
		if (emit_len > 9'(msr_pkg::EMIT_MAX)) begin
			emit_len = 9'(msr_pkg::EMIT_MAX);
		end
	end

	// A read is issued each cycle while the word has room for the bytes in flight.
	logic rd_fire, word_ready, out_free;
	assign out_free = !out_full_q || out_ready;
	assign rd_fire = ctrl.emit_step && emit_busy_q && rd_ptr_q < elen_q && !word_ready &&
		(wbyte_q + 4'(rd_pend_q)) < 4'd8;
	assign word_ready = emit_busy_q && !rd_pend_q && wbyte_q != 4'd0 &&
		(wbyte_q == 4'd8 || wcount_q == elen_q);

	logic [3:0] wvalid;
	assign wvalid = wbyte_q;

	assign stat.is_tick   = item_q.cmd;
	assign stat.out_full  = out_full_q;
	assign stat.emit_go   = data_ok && !too_many && done && good;
	assign stat.tick_last = scan_q == SW'(S - 1);
	assign stat.emit_busy = emit_busy_q;

	assign out_valid = out_full_q;
	assign out_item = out_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= msr_pkg::TIMEOUT_RESET;
			for (int i = 0; i < S; i++) begin
				sender_q[i] <= '0;
				chunks_q[i] <= '0;
				bytes_q[i]  <= '0;
				xor_q[i]    <= '0;
				age_q[i]    <= '0;
			end
			scan_q      <= '0;
			out_full_q  <= 1'b0;
			emit_busy_q <= 1'b0;
			rd_pend_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (ctrl.out_take) begin
				out_full_q <= 1'b0;
			end
			if (ctrl.load) begin
				scan_q <= '0;
			end
			// Data byte.
			if (ctrl.do_data && item_q.sender_id != 48'd0) begin
				if (!data_ok) begin
					out_full_q <= 1'b1;
				end else if (too_many) begin
					out_full_q <= 1'b1;
					sender_q[slot] <= '0;
					chunks_q[slot] <= '0;
					bytes_q[slot]  <= '0;
					xor_q[slot]    <= '0;
					age_q[slot]    <= '0;
				end else if (done) begin
					out_full_q <= !good;
					sender_q[slot] <= '0;
					chunks_q[slot] <= '0;
					bytes_q[slot]  <= '0;
					xor_q[slot]    <= '0;
					age_q[slot]    <= '0;
				end else begin
					if (!hit) begin
						age_q[slot] <= '0;
					end
					sender_q[slot] <= item_q.sender_id;
					chunks_q[slot] <= new_chunks;
					bytes_q[slot]  <= new_bytes;
					xor_q[slot]    <= new_xor;
				end
			end
			// Tick scan, one slot a cycle while the output register is free.
			if (ctrl.tick_step) begin
				scan_q <= scan_q + SW'(1);
				if (scan_busy) begin
					if (timed_out) begin
						out_full_q <= 1'b1;
						sender_q[scan_q] <= '0;
						chunks_q[scan_q] <= '0;
						bytes_q[scan_q]  <= '0;
						xor_q[scan_q]    <= '0;
						age_q[scan_q]    <= '0;
					end else begin
						age_q[scan_q] <= aged;
					end
				end
			end
			// Payload emission.
			if (ctrl.emit_start) begin
				emit_busy_q <= 1'b1;
				rd_pend_q   <= 1'b0;
			end else if (ctrl.emit_step && emit_busy_q) begin
				rd_pend_q <= rd_fire;
				if (word_ready && out_free) begin
					out_full_q <= 1'b1;
					if (wcount_q == elen_q) begin
						emit_busy_q <= 1'b0;
					end
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			item_q <= in_item;
		end
		if (ctrl.do_data) begin
			eslot_q   <= slot;
			esender_q <= item_q.sender_id;
			elen_q    <= emit_len;
			if (!data_ok) begin
				out_q <= {msr_pkg::KIND_NO_SLOT, item_q.sender_id, 64'd0, 4'd0, 1'b1};
			end else if (too_many) begin
				out_q <= {msr_pkg::KIND_TOO_MANY, item_q.sender_id, 64'd0, 4'd0, 1'b1};
			end else begin
				out_q <= {msr_pkg::KIND_CSUM_FAIL, item_q.sender_id, 64'd0, 4'd0, 1'b1};
			end
		end
		if (ctrl.tick_step) begin
			out_q <= {msr_pkg::KIND_TIMEOUT, sender_q[scan_q], 64'd0, 4'd0, 1'b1};
		end
		if (ctrl.emit_start) begin
			rd_ptr_q <= '0;
			wbyte_q  <= '0;
			wcount_q <= '0;
			word_q   <= '0;
		end else if (ctrl.emit_step && emit_busy_q) begin
			if (word_ready && out_free) begin
				out_q <= {msr_pkg::KIND_PAYLOAD, esender_q, word_q, wvalid,
					wcount_q == elen_q};
				word_q  <= '0;
				wbyte_q <= '0;
			end else if (rd_pend_q) begin
				word_q[{wbyte_q[2:0], 3'b000} +: 8] <= mem_rdata;
				wbyte_q  <= wbyte_q + 4'd1;
				wcount_q <= wcount_q + 9'd1;
			end
			if (rd_fire) begin
				rd_ptr_q <= rd_ptr_q + 9'd1;
			end
		end
	end

endmodule

// ----- design/multi_sender_chunk_reassembly.sv -----
// Reassembles chunked messages from up to SLOTS senders and checks each with
// an XOR checksum. Each input transfer is one data byte or one time tick.
// A data byte is captured, then its slot is updated, before the next
// transfer can be taken; a tick is captured, then the ageing scan walks the
// slots one at a time. Either waits while an earlier result is still held in
// the output register. A completed good message then streams its payload
// from the payload memory with one read a cycle while the word being built
// has room: after a setup state, bytes are packed into 64-bit words, each
// sent when full or at the final byte, and the receiver may hold off any
// word. No input is taken until the last word has been transferred. Status
// results are single transfers with last_word set.
module multi_sender_chunk_reassembly (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  msr_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output msr_pkg::out_item_t out_data
);

	msr_pkg::ctrl_t ctrl;
	msr_pkg::stat_t stat;

	msr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_ready(out_ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	msr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_item  (in_data),
		.ctrl     (ctrl),
		.out_ready(out_ready),
		.stat     (stat),
		.out_valid(out_valid),
		.out_item (out_data)
	);

endmodule

// ----- tb/multi_sender_chunk_reassembly_tb.sv -----
module multi_sender_chunk_reassembly_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NSLOT = msr_pkg::SLOTS;
	localparam int unsigned REGION = msr_pkg::MSG_BYTES;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	msr_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	msr_pkg::out_item_t out_data;

	multi_sender_chunk_reassembly u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #2 clk = ~clk;

	// Shadow copy of the reassembly state.
	logic [47:0] sh_sender [NSLOT];
	logic [7:0]  sh_chunks [NSLOT];
	logic [8:0]  sh_bytes [NSLOT];
	logic [7:0]  sh_xor [NSLOT];
	logic [15:0] sh_age [NSLOT];
	logic [7:0]  sh_store [NSLOT*REGION];
	logic [15:0] sh_timeout;

	msr_pkg::in_item_t  pending_items [$];
	msr_pkg::out_item_t expected_results [$];
	int          errors = 0;
	bit          hold_receiver = 0;

	function automatic void free_slot(int s);
		sh_sender[s] = '0;
		sh_chunks[s] = '0;
		sh_bytes[s] = '0;
		sh_xor[s] = '0;
		sh_age[s] = '0;
	endfunction

	function automatic void push_status(logic [2:0] k, logic [47:0] id);
		msr_pkg::out_item_t r;
		r = '0;
		r.kind = k;
		r.sender_of_result = id;
		r.last_word = 1'b1;
		expected_results.push_back(r);
	endfunction

	// Work out the results that one accepted transfer causes.
	function automatic void reassemble(msr_pkg::in_item_t it);
		int slot;
		int n;
		int cnt;
		msr_pkg::out_item_t r;
		logic [8:0] addr;
		slot = -1;
		if (it.cmd) begin
			for (int s = 0; s < NSLOT; s++) begin
				if (sh_sender[s] == 0) continue;
				if (sh_age[s] != 16'hFFFF) sh_age[s]++;
				if (sh_age[s] >= sh_timeout) begin
					push_status(msr_pkg::KIND_TIMEOUT, sh_sender[s]);
					free_slot(s);
				end
			end
			return;
		end
		if (it.sender_id == 0) return;
		for (int s = 0; s < NSLOT; s++)
			if (slot < 0 && sh_sender[s] == it.sender_id) slot = s;
		if (slot < 0) begin
			for (int s = 0; s < NSLOT; s++)
				if (slot < 0 && sh_sender[s] == 0) slot = s;
			if (slot < 0) begin
				push_status(msr_pkg::KIND_NO_SLOT, it.sender_id);
				return;
			end
			free_slot(slot);
			sh_sender[slot] = it.sender_id;
		end
		if (sh_chunks[slot] > it.total_chunks) begin
			push_status(msr_pkg::KIND_TOO_MANY, it.sender_id);
			free_slot(slot);
			return;
		end
		addr = {1'b0, it.chunk_offset} + {1'b0, it.byte_pos};
		if (addr < REGION) sh_store[slot*REGION + addr] = it.data_byte;
		if (sh_bytes[slot] != 9'd511) sh_bytes[slot]++;
		sh_xor[slot] ^= it.data_byte;
		if (!it.last_of_chunk) return;
		if (sh_chunks[slot] != 8'd255) sh_chunks[slot]++;
		if (sh_chunks[slot] != it.total_chunks) return;
		if ((sh_xor[slot] ^ it.checksum_byte) == 0) begin
			n = (sh_bytes[slot] > REGION) ? REGION : sh_bytes[slot];
			for (int i = 0; i < n; i += 8) begin
				r = '0;
				cnt = (n - i > 8) ? 8 : n - i;
				for (int b = 0; b < cnt; b++)
					r.payload_word[8*b +: 8] = sh_store[slot*REGION + i + b];
				r.kind = msr_pkg::KIND_PAYLOAD;
				r.sender_of_result = sh_sender[slot];
				r.bytes_valid = cnt[3:0];
				r.last_word = (i + 8 >= n);
				expected_results.push_back(r);
			end
		end else begin
			push_status(msr_pkg::KIND_CSUM_FAIL, it.sender_id);
		end
		free_slot(slot);
	endfunction

	// Driver: offers queued items with random gaps between them.
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				reassemble(in_data);
				void'(pending_items.pop_front());
				send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
				if ($urandom_range(0, 1)) send_gap = 0;
			end
			if (!(in_valid && !in_ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_items[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transfer and sets the receiver's stalls.
	int recv_gap = 0;
	always @(posedge clk) begin
		msr_pkg::out_item_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result kind %0d", out_data.kind);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (out_data.kind !== e.kind) begin
						$error("kind expected %0d got %0d", e.kind, out_data.kind);
						errors++;
					end
					if (out_data.sender_of_result !== e.sender_of_result) begin
						$error("sender_of_result expected %h got %h",
							e.sender_of_result, out_data.sender_of_result);
						errors++;
					end
					if (out_data.payload_word !== e.payload_word) begin
						$error("payload_word expected %h got %h",
							e.payload_word, out_data.payload_word);
						errors++;
					end
					if (out_data.bytes_valid !== e.bytes_valid) begin
						$error("bytes_valid expected %0d got %0d",
							e.bytes_valid, out_data.bytes_valid);
						errors++;
					end
					if (out_data.last_word !== e.last_word) begin
						$error("last_word expected %0d got %0d",
							e.last_word, out_data.last_word);
						errors++;
					end
				end
				recv_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
			end
			if (hold_receiver) begin
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Builds the items of one message; a bad checksum is made on request.
	task automatic queue_message(logic [47:0] id, int nchunks, int chunk_len,
			bit good_sum, bit wrap_addr);
		msr_pkg::in_item_t it;
		logic [7:0] x;
		x = '0;
		for (int c = 0; c < nchunks; c++) begin
			for (int b = 0; b < chunk_len; b++) begin
				it = '0;
				it.sender_id = id;
				it.total_chunks = nchunks[7:0];
				it.chunk_offset = wrap_addr ? 8'd250 : 8'(c * chunk_len);
				it.byte_pos = 8'(b);
				it.data_byte = 8'($urandom);
				x ^= it.data_byte;
				it.last_of_chunk = (b == chunk_len - 1);
				pending_items.push_back(it);
			end
		end
		pending_items[$].checksum_byte = good_sum ? x : ~x;
	endtask

	task automatic queue_tick();
		msr_pkg::in_item_t it;
		it = '0;
		it.cmd = 1'b1;
		it.sender_id = 48'({$urandom, $urandom});
		it.total_chunks = 8'($urandom);
		it.data_byte = 8'($urandom);
		it.last_of_chunk = 1'($urandom);
		pending_items.push_back(it);
	endtask

	// A stray byte from an unknown sender; its checksum never matches, so it
	// cannot release a payload that was never stored.
	task automatic queue_noise();
		msr_pkg::in_item_t it;
		it.cmd = 1'b0;
		it.sender_id = 48'({$urandom, $urandom});
		if ($urandom_range(0, 5) == 0) it.sender_id = '0;
		it.total_chunks = 8'($urandom);
		it.chunk_offset = 8'($urandom);
		it.byte_pos = 8'($urandom);
		it.data_byte = 8'($urandom);
		it.last_of_chunk = 1'($urandom);
		it.checksum_byte = ~it.data_byte;
		pending_items.push_back(it);
	endtask

	// Waits until the block has drained and leaves it time to settle.
	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_timeout(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		sh_timeout = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Directed part, then random phases over several timeout settings.
	initial begin
		msr_pkg::in_item_t it;
		bit wr;
		for (int s = 0; s < NSLOT; s++) free_slot(s);
		for (int i = 0; i < NSLOT*REGION; i++) sh_store[i] = '0;
		sh_timeout = msr_pkg::TIMEOUT_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_timeout(16'd65535);
		queue_message(48'hFFFF_FFFF_FFFF, 1, 8, 1, 0);
		queue_message(48'd1, 2, 3, 0, 0);
		queue_message(48'd2, 1, 2, 1, 1);
		it = '0;
		it.sender_id = '0;
		pending_items.push_back(it);
		for (int s = 0; s < 4; s++) begin
			it = '0;
			it.sender_id = 48'(10 + s);
			it.total_chunks = 8'd5;
			pending_items.push_back(it);
		end
		it.sender_id = 48'd20;
		pending_items.push_back(it);
		it.sender_id = 48'd10;
		it.total_chunks = 8'd0;
		it.last_of_chunk = 1'b1;
		pending_items.push_back(it);
		it.last_of_chunk = 1'b0;
		pending_items.push_back(it);
		drain();

		// Timeout zero clears every busy slot on the next tick.
		set_timeout(16'd0);
		queue_tick();
		drain();

		// Long receiver hold-off while a 40-byte message and a follower are offered.
		set_timeout(16'd1);
		queue_message(48'h5A5A, 1, 40, 1, 0);
		queue_message(48'h5A5B, 2, 10, 1, 0);
		fork
			begin
				hold_receiver = 1;
				repeat (600) @(posedge clk);
				hold_receiver = 0;
			end
		join_none
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			set_timeout(ph == 0 ? 16'd3 : ph == 1 ? 16'd1 : ph == 2 ? 16'd20 : 16'd1000);
			for (int m = 0; m < 16; m++) begin
				case ($urandom_range(0, 9))
					0, 1: queue_tick();
					2: queue_noise();
					default: begin
						// Messages placed at offset 250, near the region's end, only ever end in a failed check.
						wr = $urandom_range(0, 7) == 0;
						queue_message(48'(1 + $urandom_range(0, 6)),
							$urandom_range(1, 3), $urandom_range(1, 6),
							!wr && $urandom_range(0, 3) != 0, wr);
					end
				endcase
			end
			drain();
		end

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end
endmodule
